[rtl/gbn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

	// Sequence space and window size.
	localparam int MaxSeqNum = 7;
	localparam int SeqSpace  = MaxSeqNum + 1;
	localparam int SeqW      = $clog2(SeqSpace);
	localparam int PayloadW  = 32;

	// Depth of the queue between the front and back parts.
	localparam int CmdDepth = 4;
	localparam int CmdPtrW  = $clog2(CmdDepth);

	typedef enum logic [1:0] {
		REQ_DATA    = 2'd0,
		REQ_ACK     = 2'd1,
		REQ_TIMEOUT = 2'd2
	} req_kind_t;

	typedef enum logic [2:0] {
		RES_SENT        = 3'd0,
		RES_ACK_OK      = 3'd1,
		RES_ACK_IGNORED = 3'd2,
		RES_WINDOW_FULL = 3'd3,
		RES_NOTHING     = 3'd4
	} result_kind_t;

	typedef enum logic [1:0] {
		OP_SEND,
		OP_RESEND,
		OP_INFO
	} cmd_op_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [PayloadW-1:0] payload;
		logic [SeqW-1:0]     ack_number;
	} req_item_t;

	typedef struct packed {
		result_kind_t        result_kind;
		logic [SeqW-1:0]     frame_seq;
		logic [PayloadW-1:0] frame_payload;
		logic [SeqW-1:0]     freed_count;
		logic [SeqW-1:0]     outstanding;
		logic                last_of_run;
	} res_item_t;

	typedef struct packed {
		cmd_op_t             op;
		result_kind_t        kind;
		logic [SeqW-1:0]     seq;
		logic [PayloadW-1:0] payload;
		logic [SeqW-1:0]     freed;
		logic [SeqW-1:0]     outstanding;
	} cmd_t;

	function automatic logic [SeqW-1:0] seq_add(input logic [SeqW-1:0] a,
		input logic [SeqW-1:0] b);
		logic [SeqW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (SeqW+1)'(SeqSpace)) begin
			s = s - (SeqW+1)'(SeqSpace);
		end
		return s[SeqW-1:0];
	endfunction

	function automatic logic [SeqW-1:0] seq_sub(input logic [SeqW-1:0] a,
		input logic [SeqW-1:0] b);
		logic [SeqW:0] s;
		s = {1'b0, a} + (SeqW+1)'(SeqSpace) - {1'b0, b};
		if (s >= (SeqW+1)'(SeqSpace)) begin
			s = s - (SeqW+1)'(SeqSpace);
		end
		return s[SeqW-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/gbn_cmd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbn_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  gbn_pkg::cmd_t      wr_data,
	output logic               full,
	input  wire logic          pop,
	output gbn_pkg::cmd_t      rd_data,
	output logic               empty
);
	import gbn_pkg::*;

	cmd_t               entries_q [CmdDepth];
	logic [CmdPtrW-1:0] wr_ptr_q;
	logic [CmdPtrW-1:0] rd_ptr_q;
	logic [CmdPtrW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == (CmdPtrW+1)'(CmdDepth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CmdPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CmdPtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (CmdPtrW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (CmdPtrW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	// The front part holds back while the queue is full, so no request is dropped here.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request pushed into a full command queue");

endmodule

`default_nettype wire

[rtl/gbn_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbn_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  gbn_pkg::req_item_t request,
	output logic               cmd_push,
	output gbn_pkg::cmd_t      cmd_data,
	input  wire logic          cmd_full
);
	import gbn_pkg::*;

	logic [SeqW-1:0] next_seq_q;
	logic [SeqW-1:0] oldest_q;
	logic [SeqW-1:0] count_q;
	logic [SeqW-1:0] next_seq_d;
	logic [SeqW-1:0] oldest_d;
	logic [SeqW-1:0] count_d;
	logic [SeqW-1:0] ack_offset;
	logic [SeqW-1:0] freed;
	logic            accept;
	logic            emits;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	always_comb begin
		cmd_data             = '0;
		cmd_data.op          = OP_INFO;
		cmd_data.kind        = RES_ACK_IGNORED;
		cmd_data.outstanding = count_q;
		next_seq_d           = next_seq_q;
		oldest_d             = oldest_q;
		count_d              = count_q;
		emits                = 1'b1;
		ack_offset           = seq_sub(request.ack_number, oldest_q);
		freed                = ack_offset + SeqW'(1);
		case (request.req_type)
			REQ_DATA: begin
				if (count_q >= SeqW'(MaxSeqNum)) begin
					cmd_data.kind = RES_WINDOW_FULL;
				end else begin
					cmd_data.op          = OP_SEND;
					cmd_data.kind        = RES_SENT;
					cmd_data.seq         = next_seq_q;
					cmd_data.payload     = request.payload;
					cmd_data.outstanding = count_q + SeqW'(1);
					count_d              = count_q + SeqW'(1);
					next_seq_d           = seq_add(next_seq_q, SeqW'(1));
				end
			end
			REQ_ACK: begin
				// A cumulative ack counts only if it names an outstanding frame.
				if (ack_offset < count_q) begin
					cmd_data.kind        = RES_ACK_OK;
					cmd_data.freed       = freed;
					cmd_data.outstanding = count_q - freed;
					count_d              = count_q - freed;
					oldest_d             = seq_add(oldest_q, freed);
				end
			end
			REQ_TIMEOUT: begin
				if (count_q == '0) begin
					cmd_data.kind = RES_NOTHING;
				end else begin
					cmd_data.op   = OP_RESEND;
					cmd_data.kind = RES_SENT;
					cmd_data.seq  = oldest_q;
				end
			end
			default: begin
				emits = 1'b0;
			end
		endcase
	end

	assign cmd_push = accept && emits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= '0;
			oldest_q   <= '0;
			count_q    <= '0;
		end else if (accept) begin
			next_seq_q <= next_seq_d;
			oldest_q   <= oldest_d;
			count_q    <= count_d;
		end
	end

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SeqW'(MaxSeqNum))
		else $error("more frames outstanding than the window allows");

	a_window_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		seq_add(oldest_q, count_q) == next_seq_q)
		else $error("window edges disagree with the outstanding count");

endmodule

`default_nettype wire

[rtl/gbn_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbn_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  gbn_pkg::cmd_t      head,
	input  wire logic          head_empty,
	output logic               head_pop,
	output logic               empty,
	input  wire logic          pop,
	output gbn_pkg::res_item_t result
);
	import gbn_pkg::*;

	logic [PayloadW-1:0] tx_buffer [SeqSpace];
	logic                out_valid_q;
	res_item_t           out_q;
	res_item_t           out_d;
	logic [SeqW-1:0]     rs_idx_q;
	logic [SeqW-1:0]     rs_seq;
	logic                rs_last;
	logic                fire;
	logic                is_send;
	logic                is_resend;

	assign empty  = !out_valid_q;
	assign result = out_q;

	// The output register is free when empty or being taken in this cycle.
	assign fire      = !head_empty && (!out_valid_q || pop);
	assign is_send   = (head.op == OP_SEND);
	assign is_resend = (head.op == OP_RESEND);
	assign rs_seq    = seq_add(head.seq, rs_idx_q);
	assign rs_last   = ((rs_idx_q + SeqW'(1)) == head.outstanding);

	always_comb begin
		out_d             = '0;
		out_d.result_kind = head.kind;
		out_d.outstanding = head.outstanding;
		out_d.last_of_run = 1'b1;
		head_pop          = fire;
		case (head.op)
			OP_SEND: begin
				out_d.frame_seq     = head.seq;
				out_d.frame_payload = head.payload;
			end
			OP_RESEND: begin
				// One frame per cycle while the output register is free; the command leaves the queue with its last frame.
				out_d.frame_seq   = rs_seq;
				out_d.last_of_run = rs_last;
				head_pop          = fire && rs_last;
			end
			OP_INFO: begin
				out_d.freed_count = head.freed;
			end
			default: begin
				out_d.last_of_run = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rs_idx_q    <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (fire && is_resend) begin
				rs_idx_q <= rs_last ? '0 : rs_idx_q + SeqW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (is_send) begin
				tx_buffer[head.seq] <= head.payload;
			end
			if (is_resend) begin
				out_q <= {out_d.result_kind, out_d.frame_seq, tx_buffer[rs_seq],
					out_d.freed_count, out_d.outstanding, out_d.last_of_run};
			end else begin
				out_q <= out_d;
			end
		end
	end

	a_resend_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!head_empty && is_resend) |-> (rs_idx_q < head.outstanding))
		else $error("resend index ran past the outstanding frames");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(head_empty || !is_resend) |-> (rs_idx_q == '0))
		else $error("resend index left nonzero outside a resend");

endmodule

`default_nettype wire

[rtl/go_back_n_sender_window.sv]
`timescale 1ns / 1ps
`default_nettype none
// A result passes through the command queue and then the output register to the result ports.
// Throughput: one new-data or ack request per cycle unless the command queue is full; a timeout
// gives one resent frame per cycle while results are taken, and occupies the back part until its last frame.
// A four-entry command queue lets the front take requests while the back is resending.
// Reset clears the window counters, the queue and the result valid flag; the frame
// buffer is not cleared and needs no clearing pass.

module go_back_n_sender_window (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  gbn_pkg::req_item_t request,
	output logic               empty,
	input  wire logic          pop,
	output gbn_pkg::res_item_t result
);
	import gbn_pkg::*;

	logic cmd_push;
	cmd_t cmd_wr;
	logic cmd_full;
	cmd_t cmd_head;
	logic cmd_empty;
	logic cmd_pop;

	gbn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.cmd_push (cmd_push),
		.cmd_data (cmd_wr),
		.cmd_full (cmd_full)
	);

	gbn_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	gbn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (cmd_head),
		.head_empty (cmd_empty),
		.head_pop   (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire
